>>> rtl/mtf_pkg.sv
package mtf_pkg;

    localparam int DEPTH     = 16;
    localparam int KEY_WIDTH = 16;
    localparam int COUNT_W   = $clog2(DEPTH + 1);
    localparam int INDEX_W   = $clog2(DEPTH);

    typedef logic [KEY_WIDTH-1:0] key_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [INDEX_W-1:0]   index_t;
    typedef logic [3:0]           pos_t;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_MOVE   = 2'd2
    } cmd_e;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] key;
    } in_t;

    typedef struct packed {
        logic found;
        pos_t position;
        logic dropped;
    } out_t;

    typedef struct packed {
        logic push;
        logic move;
        logic found;
    } cell_ctrl_t;

    typedef struct packed {
        key_t key;
        logic valid;
        logic seen;
    } link_t;

endpackage

>>> rtl/mtf_cell.sv
module mtf_cell
    import mtf_pkg::*;
(
    input  logic       clk,
    input  logic       valid,
    input  key_t       key,
    input  cell_ctrl_t ctrl,
    input  link_t      prev,
    output link_t      next,
    output logic       first
);

    key_t entry_key_reg;
    key_t entry_key_next;
    logic match;
    logic load;

    assign match = valid && (entry_key_reg == key);
    assign first = match && !prev.seen;

    // take the neighbor's entry on push, or up to the first hit on move
    assign load = (ctrl.push && prev.valid) || (ctrl.move && ctrl.found && !prev.seen);

    assign next.key   = entry_key_reg;
    assign next.valid = valid;
    assign next.seen  = prev.seen || match;

    always_comb
    begin
        entry_key_next = entry_key_reg;
        if (load)
        begin
            entry_key_next = prev.key;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_key_reg <= entry_key_next;
    end

endmodule

>>> rtl/move_to_front_list_search.sv
// Channel | Direction | Handshake             | Beat
// cmd     | in        | cmd_valid / cmd_stall | cmd_beat (cmd, key)
// res     | out       | res_valid / res_stall | res_beat (found, position, dropped)
//
// One result beat per command beat; each passes the command stage, then the result register.
// Compare, first-hit search and list shift run together through the cell row, the shift registered in the cells.
// A new command is taken in the cycle the previous one completes: one per cycle while res is not stalled.
// Reset empties the list at once; entry keys are not cleared.
// A stalled result holds the command stage, which then stalls cmd.
module move_to_front_list_search
    import mtf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  in_t  cmd_beat,
    output logic res_valid,
    input  logic res_stall,
    output out_t res_beat
);

    logic       op_valid_reg;
    logic       op_valid_next;
    logic [1:0] op_cmd_reg;
    logic [1:0] op_cmd_next;
    key_t       op_key_reg;
    key_t       op_key_next;
    count_t     count_reg;
    count_t     count_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_t       out_beat_reg;
    out_t       out_beat_next;

    logic       done;
    logic       accept;
    logic       full;
    cell_ctrl_t ctrl;
    link_t      links [DEPTH+1];
    logic [DEPTH-1:0] cell_valid;
    logic [DEPTH-1:0] first_vec;
    index_t     hit_index;

    assign full      = (count_reg == count_t'(DEPTH));
    assign done      = op_valid_reg && (!out_valid_reg || !res_stall);
    assign cmd_stall = op_valid_reg && !done;
    assign accept    = cmd_valid && !cmd_stall;

    assign links[0].key   = op_key_reg;
    assign links[0].valid = 1'b1;
    assign links[0].seen  = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            assign cell_valid[gi] = (count_t'(gi) < count_reg);

            mtf_cell u_cell (
                .clk   (clk),
                .valid (cell_valid[gi]),
                .key   (op_key_reg),
                .ctrl  (ctrl),
                .prev  (links[gi]),
                .next  (links[gi+1]),
                .first (first_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        hit_index = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (first_vec[i])
            begin
                hit_index = hit_index | index_t'(i);
            end
        end
    end

    always_comb
    begin
        ctrl.push  = 1'b0;
        ctrl.move  = 1'b0;
        ctrl.found = links[DEPTH].seen;
        count_next = count_reg;
        out_beat_next = '0;
        if (done)
        begin
            unique case (op_cmd_reg)
                CMD_PUSH:
                begin
                    ctrl.push = 1'b1;
                    out_beat_next.dropped = full;
                    if (!full)
                    begin
                        count_next = count_reg + count_t'(1);
                    end
                end
                CMD_SEARCH:
                begin
                    out_beat_next.found    = links[DEPTH].seen;
                    out_beat_next.position = pos_t'(hit_index);
                end
                CMD_MOVE:
                begin
                    ctrl.move = 1'b1;
                    out_beat_next.found    = links[DEPTH].seen;
                    out_beat_next.position = pos_t'(hit_index);
                end
                default:
                begin
                    out_beat_next = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        op_valid_next  = op_valid_reg && !done;
        op_cmd_next    = op_cmd_reg;
        op_key_next    = op_key_reg;
        out_valid_next = out_valid_reg && res_stall;
        if (accept)
        begin
            op_valid_next = 1'b1;
            op_cmd_next   = cmd_beat.cmd;
            op_key_next   = key_t'(cmd_beat.key);
        end
        if (done)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            op_valid_reg  <= op_valid_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_cmd_reg <= op_cmd_next;
        op_key_reg <= op_key_next;
        if (done)
        begin
            out_beat_reg <= out_beat_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_beat  = out_beat_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= count_t'(DEPTH))
        else $error("entry count above depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(first_vec))
        else $error("more than one first hit");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && (op_cmd_reg == CMD_PUSH) && !full |=> count_reg == $past(count_reg) + count_t'(1))
        else $error("push did not grow the list");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_beat.found && res_beat.dropped))
        else $error("found and dropped together");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && (op_cmd_reg != CMD_PUSH) |=> count_reg == $past(count_reg))
        else $error("search changed the entry count");

endmodule

>>> sim/tb_move_to_front_list_search.sv
`timescale 1ns / 100ps

module tb_move_to_front_list_search;
    import mtf_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 1075;
    localparam int         LONG_HOLD    = 200;
    localparam int         BURST_ITEMS  = 40;
    localparam int         DRAIN_CYCLES = 8;
    localparam out_t       ALL_ZERO     = '0;

    typedef struct {
        logic [1:0] cmd;
        key_t       key;
        logic       typed;
        out_t       want;
    } directed_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    in_t  cmd_beat  = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    out_t res_beat;

    key_t mtf_list [DEPTH];
    int   list_len     = 0;
    out_t expected_results [$];
    int   mismatches   = 0;
    int   send_calm    = 0;
    int   recv_calm    = 0;
    int   burst_left   = 0;
    bit   hold_request = 1'b0;
    out_t oldest;

    directed_row_t directed [25] = '{
        '{CMD_SEARCH, 16'h0000, 1'b1, ALL_ZERO},
        '{CMD_UNUSED, 16'hFFFF, 1'b1, ALL_ZERO},
        '{CMD_PUSH,   16'h0000, 1'b0, ALL_ZERO},
        '{CMD_PUSH,   16'hFFFF, 1'b0, ALL_ZERO},
        '{CMD_MOVE,   16'h0000, 1'b1, '{1'b1, 4'd1, 1'b0}},
        '{CMD_MOVE,   16'h0000, 1'b1, '{1'b1, 4'd0, 1'b0}},
        '{CMD_PUSH,   16'h0000, 1'b0, ALL_ZERO},
        '{CMD_SEARCH, 16'hFFFF, 1'b1, '{1'b1, 4'd2, 1'b0}},
        '{CMD_PUSH,   16'h0001, 1'b0, ALL_ZERO},
        '{CMD_PUSH,   16'h0002, 1'b0, ALL_ZERO},
        '{CMD_PUSH,   16'h0004, 1'b0, ALL_ZERO},
        '{CMD_PUSH,   16'h0008, 1'b0, ALL_ZERO},
        '{CMD_PUSH,   16'h0010, 1'b0, ALL_ZERO},
        '{CMD_PUSH,   16'h0020, 1'b0, ALL_ZERO},
        '{CMD_PUSH,   16'h0040, 1'b0, ALL_ZERO},
        '{CMD_PUSH,   16'h0080, 1'b0, ALL_ZERO},
        '{CMD_PUSH,   16'h0100, 1'b0, ALL_ZERO},
        '{CMD_PUSH,   16'h0200, 1'b0, ALL_ZERO},
        '{CMD_PUSH,   16'h0400, 1'b0, ALL_ZERO},
        '{CMD_PUSH,   16'h0800, 1'b0, ALL_ZERO},
        '{CMD_PUSH,   16'h1000, 1'b0, ALL_ZERO},
        '{CMD_PUSH,   16'hA5A5, 1'b1, '{1'b0, 4'd0, 1'b1}},
        '{CMD_SEARCH, 16'hFFFF, 1'b1, ALL_ZERO},
        '{CMD_MOVE,   16'h0000, 1'b1, '{1'b1, 4'd14, 1'b0}},
        '{CMD_SEARCH, 16'h0001, 1'b0, ALL_ZERO}
    };

    move_to_front_list_search uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_beat  (cmd_beat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_beat  (res_beat)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic out_t apply_command(in_t beat);
        out_t r;
        key_t k;
        int   hit;
        r   = '0;
        k   = beat.key[KEY_WIDTH-1:0];
        hit = -1;
        case (beat.cmd) inside
            CMD_PUSH:
            begin
                if (list_len >= DEPTH)
                    r.dropped = 1'b1;
                else
                    list_len++;
                for (int i = DEPTH - 1; i > 0; i--)
                    mtf_list[i] = mtf_list[i-1];
                mtf_list[0] = k;
            end
            CMD_SEARCH, CMD_MOVE:
            begin
                for (int i = 0; i < list_len && hit < 0; i++)
                    if (mtf_list[i] == k)
                        hit = i;
                if (hit >= 0)
                begin
                    r.found    = 1'b1;
                    r.position = pos_t'(hit);
                    if (beat.cmd == CMD_MOVE)
                    begin
                        for (int i = hit; i > 0; i--)
                            mtf_list[i] = mtf_list[i-1];
                        mtf_list[0] = k;
                    end
                end
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic in_t random_command();
        in_t b;
        int  pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            b.cmd = CMD_PUSH;
        else if (pick < 60)
            b.cmd = CMD_SEARCH;
        else if (pick < 95)
            b.cmd = CMD_MOVE;
        else
            b.cmd = CMD_UNUSED;
        pick = $urandom_range(0, 9);
        if (pick < 5 && list_len > 0)
            b.key = mtf_list[$urandom_range(0, list_len - 1)];
        else if (pick < 8)
            b.key = 16'h5A00 | 16'($urandom_range(0, 23));
        else
            b.key = 16'($urandom());
        return b;
    endfunction

    task automatic send_command(in_t beat, logic typed, out_t want);
        int   gap;
        logic took;
        out_t predicted;
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
            gap = draw_wait(send_calm);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_beat  <= beat;
        do
        begin
            @(negedge clk);
            took = !cmd_stall;
            @(posedge clk);
        end
        while (!took);
        predicted = apply_command(beat);
        expected_results.push_back(typed ? want : predicted);
    endtask

    function automatic void note_mismatch(out_t want, out_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: expected found=%0b position=%0d dropped=%0b",
                     want.found, want.position, want.dropped,
                     ", got found=%0b position=%0d dropped=%0b",
                     got.found, got.position, got.dropped);
    endfunction

    always @(negedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat with no command pending:",
                             " found=%0b position=%0d dropped=%0b",
                             res_beat.found, res_beat.position, res_beat.dropped);
            end
            else
            begin
                oldest = expected_results.pop_front();
                if (res_beat.found !== oldest.found || res_beat.position !== oldest.position
                    || res_beat.dropped !== oldest.dropped)
                    note_mismatch(oldest, res_beat);
            end
        end
    end

    initial
    begin
        int   gap;
        logic took;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                gap = LONG_HOLD;
            end
            else
                gap = draw_wait(recv_calm);
            if (gap > 0)
            begin
                res_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            res_stall <= 1'b0;
            do
            begin
                @(negedge clk);
                took = res_valid;
                @(posedge clk);
            end
            while (!took);
        end
    end

    initial
    begin
        in_t row_beat;
        foreach (mtf_list[i])
            mtf_list[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        foreach (directed[i])
        begin
            row_beat.cmd = directed[i].cmd;
            row_beat.key = directed[i].key;
            send_command(row_beat, directed[i].typed, directed[i].want);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 300)
            begin
                hold_request = 1'b1;
                burst_left   = BURST_ITEMS;
            end
            if (n == 650)
            begin
                cmd_valid <= 1'b0;
                while (expected_results.size() != 0)
                    @(posedge clk);
            end
            send_command(random_command(), 1'b0, ALL_ZERO);
        end
        cmd_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
